FILE: rtl/core/rhc_pkg.sv
// Shared constants, field layout and channel codes for the RGB to HSV converter.
// No dependencies; every other file in rtl/core depends on this package.
package rhc_pkg;

    // Channel width and stream layout
    localparam int CHAN_BITS_DEF = 8;
    localparam int IN_CHAN_W     = 8;
    localparam int S_TDATA_W     = 24;

    localparam int HUE_W     = 15;
    localparam int SAT_W     = 16;
    localparam int VAL_W     = 8;
    localparam int HUE_LSB   = 0;
    localparam int SAT_LSB   = HUE_LSB + HUE_W;
    localparam int VAL_LSB   = SAT_LSB + SAT_W;
    localparam int M_TDATA_W = 40;
    localparam int PAD_W     = M_TDATA_W - HUE_W - SAT_W - VAL_W;

    // Quotient bits produced by each divider (one per pipeline step)
    localparam int QUO_W = 16;

    // Fixed-point scale factors: hue in 1/64 degree, saturation in 1/256
    localparam int HUE_SCALE   = 3840;   // 60 * 64
    localparam int SECTOR_STEP = 7680;   // 120 * 64
    localparam int HUE_WRAP    = 23040;  // 360 * 64
    localparam int SAT_SCALE   = 65280;  // 255 * 256

    localparam int HUE_MAX = HUE_WRAP - 1;
    localparam int SAT_MAX = SAT_SCALE;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_sel_t;

endpackage

FILE: rtl/core/rhc_prep.sv
// Front end of the converter: extremes, span and both divider numerators.
// Three register stages; depends on rhc_pkg.
module rhc_prep #(
    parameter int CHANNEL_BITS = rhc_pkg::CHAN_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [rhc_pkg::IN_CHAN_W-1:0]          red_in,
    input  logic [rhc_pkg::IN_CHAN_W-1:0]          green_in,
    input  logic [rhc_pkg::IN_CHAN_W-1:0]          blue_in,
    output logic                                   out_valid,
    output logic [CHANNEL_BITS+rhc_pkg::QUO_W-1:0] hue_num,
    output logic [CHANNEL_BITS-1:0]                hue_den,
    output logic [CHANNEL_BITS+rhc_pkg::QUO_W-1:0] sat_num,
    output logic [CHANNEL_BITS-1:0]                sat_den
);
    import rhc_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int NUM_W = CB + QUO_W;
    localparam int HN_W  = CB + QUO_W + 1;

    // Stage 1: max, min and the two channels that follow the max
    logic [CB-1:0] red, green, blue;
    logic [CB-1:0] hi_next, lo_next, nx_next, fw_next;
    chan_sel_t     sel_next;

    logic          v1_reg;
    logic [CB-1:0] hi1_reg, lo1_reg, nx1_reg, fw1_reg;
    chan_sel_t     sel1_reg;

    assign red   = CB'(red_in);
    assign green = CB'(green_in);
    assign blue  = CB'(blue_in);

    always_comb begin
        hi_next  = red;
        sel_next = CH_RED;
        if (green > hi_next) begin
            hi_next  = green;
            sel_next = CH_GREEN;
        end
        if (blue > hi_next) begin
            hi_next  = blue;
            sel_next = CH_BLUE;
        end
        lo_next = red;
        if (green < lo_next) lo_next = green;
        if (blue < lo_next)  lo_next = blue;
    end

    always_comb begin
        unique case (sel_next)
            CH_RED: begin
                nx_next = green;
                fw_next = blue;
            end
            CH_GREEN: begin
                nx_next = blue;
                fw_next = red;
            end
            CH_BLUE: begin
                nx_next = red;
                fw_next = green;
            end
            default: begin
                nx_next = green;
                fw_next = blue;
            end
        endcase
    end

    // Stage 2: span, signed difference, saturation numerator
    logic [CB-1:0]        span2_next;
    logic signed [CB:0]   d2_next;
    logic [NUM_W-1:0]     satn2_next;

    logic                 v2_reg;
    logic [CB-1:0]        hi2_reg, span2_reg;
    logic signed [CB:0]   d2_reg;
    logic [NUM_W-1:0]     satn2_reg;
    chan_sel_t            sel2_reg;

    assign span2_next = hi1_reg - lo1_reg;
    assign d2_next    = $signed({1'b0, nx1_reg}) - $signed({1'b0, fw1_reg});
    assign satn2_next = NUM_W'(span2_next) * NUM_W'(SAT_SCALE);

    // Stage 3: hue numerator, wrapped into the positive range
    logic signed [HN_W-1:0] span_s, hue_mul, hue_off, hue_sum;
    logic [NUM_W-1:0]       huen3_next;

    logic                   v3_reg;
    logic [NUM_W-1:0]       huen3_reg, satn3_reg;
    logic [CB-1:0]          span3_reg, hi3_reg;

    assign span_s  = $signed(HN_W'(span2_reg));
    assign hue_mul = HN_W'(d2_reg) * HN_W'(HUE_SCALE);

    always_comb begin
        unique case (sel2_reg)
            CH_RED:   hue_off = d2_reg[CB] ? span_s * HN_W'(HUE_WRAP) : '0;
            CH_GREEN: hue_off = span_s * HN_W'(SECTOR_STEP);
            CH_BLUE:  hue_off = span_s * HN_W'(2 * SECTOR_STEP);
            default:  hue_off = '0;
        endcase
    end

    assign hue_sum    = hue_mul + hue_off;
    assign huen3_next = hue_sum[NUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi1_reg   <= hi_next;
            lo1_reg   <= lo_next;
            nx1_reg   <= nx_next;
            fw1_reg   <= fw_next;
            sel1_reg  <= sel_next;

            hi2_reg   <= hi1_reg;
            span2_reg <= span2_next;
            d2_reg    <= d2_next;
            satn2_reg <= satn2_next;
            sel2_reg  <= sel1_reg;

            huen3_reg <= huen3_next;
            satn3_reg <= satn2_reg;
            span3_reg <= span2_reg;
            hi3_reg   <= hi2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign hue_num   = huen3_reg;
    assign hue_den   = span3_reg;
    assign sat_num   = satn3_reg;
    assign sat_den   = hi3_reg;

endmodule

FILE: rtl/core/rhc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Needs numerator < denominator * 2^QUO_W; gives zero for a zero divisor. Depends on rhc_pkg.
module rhc_div #(
    parameter int DEN_W = rhc_pkg::CHAN_BITS_DEF,
    parameter int QUO_W = rhc_pkg::QUO_W
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic [QUO_W-1:0]       quo
);
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] lq_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    logic [DEN_W-1:0] rem_src [QUO_W];
    logic [QUO_W-1:0] lq_src  [QUO_W];
    logic [DEN_W-1:0] den_src [QUO_W];

    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] lq_next  [QUO_W];

    // Stage sources: the first step takes the operands, the rest the stage before
    always_comb begin
        rem_src[0] = num[DEN_W+QUO_W-1:QUO_W];
        lq_src[0]  = num[QUO_W-1:0];
        den_src[0] = den;
        for (int j = 1; j < QUO_W; j++) begin
            rem_src[j] = rem_reg[j-1];
            lq_src[j]  = lq_reg[j-1];
            den_src[j] = den_reg[j-1];
        end
    end

    // Shift in the next numerator bit, trial-subtract, keep on no borrow
    always_comb begin
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] trial;
        for (int j = 0; j < QUO_W; j++) begin
            shifted     = {rem_src[j], lq_src[j][QUO_W-1]};
            trial       = {1'b0, shifted} - {2'b00, den_src[j]};
            rem_next[j] = trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
            lq_next[j]  = {lq_src[j][QUO_W-2:0], ~trial[DEN_W+1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < QUO_W; j++) begin
                rem_reg[j] <= rem_next[j];
                lq_reg[j]  <= lq_next[j];
                den_reg[j] <= den_src[j];
            end
        end
    end

    assign quo = (den_reg[QUO_W-1] == '0) ? '0 : lq_reg[QUO_W-1];

endmodule

FILE: rtl/core/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: stream ports, front end, two dividers,
// output register. Depends on rhc_pkg, rhc_prep and rhc_div.
//
// Converts one RGB pixel per clock while m_tready does not stall, into hue (1/64
// degree), saturation (1/256 units) and value. A pixel beat is taken in every
// cycle in which the output register is empty or is being drained, so sustained
// throughput is one pixel per clock while the sink takes every beat. An accepted
// input beat passes three front-end stages (extremes, span, numerators), QUO_W
// stages of the two restoring dividers running side by side, one quotient bit
// per stage, and the output register. The whole pipeline moves on a single
// enable, so a stall on m_tready holds every stage in place and nothing is
// dropped or repeated. A grey pixel gives hue 0, a black pixel gives hue 0 and
// saturation 0.
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS = rhc_pkg::CHAN_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rhc_pkg::S_TDATA_W-1:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rhc_pkg::M_TDATA_W-1:0] m_tdata    // hue_out[14:0], sat_out[30:15],
                                                     // value_out[38:31], zero pad[39]
);
    import rhc_pkg::*;

    localparam int NUM_W = CHANNEL_BITS + QUO_W;

    // Advance the whole pipeline whenever the output register can take a beat
    logic en;

    logic                    prep_valid;
    logic [NUM_W-1:0]        hue_num, sat_num;
    logic [CHANNEL_BITS-1:0] hue_den, sat_den;
    logic [QUO_W-1:0]        hue_quo, sat_quo;

    // Valid and value travel beside the dividers
    logic             dly_valid_reg [QUO_W];
    logic [VAL_W-1:0] dly_value_reg [QUO_W];

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    rhc_prep #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .red_in    (s_tdata[IN_CHAN_W-1:0]),
        .green_in  (s_tdata[2*IN_CHAN_W-1:IN_CHAN_W]),
        .blue_in   (s_tdata[3*IN_CHAN_W-1:2*IN_CHAN_W]),
        .out_valid (prep_valid),
        .hue_num   (hue_num),
        .hue_den   (hue_den),
        .sat_num   (sat_num),
        .sat_den   (sat_den)
    );

    // Hue: wrapped numerator over the span
    rhc_div #(
        .DEN_W (CHANNEL_BITS),
        .QUO_W (QUO_W)
    ) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (hue_num),
        .den  (hue_den),
        .quo  (hue_quo)
    );

    // Saturation: scaled span over the maximum
    rhc_div #(
        .DEN_W (CHANNEL_BITS),
        .QUO_W (QUO_W)
    ) u_sat_div (
        .aclk (aclk),
        .en   (en),
        .num  (sat_num),
        .den  (sat_den),
        .quo  (sat_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < QUO_W; j++) dly_valid_reg[j] <= 1'b0;
        end else if (en) begin
            dly_valid_reg[0] <= prep_valid;
            for (int j = 1; j < QUO_W; j++) dly_valid_reg[j] <= dly_valid_reg[j-1];
        end
    end

    // Value is the maximum, which is also the saturation divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_value_reg[0] <= VAL_W'(sat_den);
            for (int j = 1; j < QUO_W; j++) dly_value_reg[j] <= dly_value_reg[j-1];
        end
    end

    assign m_tdata_next = {{PAD_W{1'b0}}, dly_value_reg[QUO_W-1], sat_quo[SAT_W-1:0],
                           hue_quo[HUE_W-1:0]};

    // Output register: load on enable, hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dly_valid_reg[QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/rhc_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter.
module rhc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rhc_pkg::M_TDATA_W-1:0] m_tdata
);
    import rhc_pkg::*;

    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [PAD_W-1:0] pad;

    assign hue = m_tdata[HUE_LSB +: HUE_W];
    assign sat = m_tdata[SAT_LSB +: SAT_W];
    assign pad = m_tdata[M_TDATA_W-1 -: PAD_W];

    // Hue stays below a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hue <= HUE_WRAP - 1)
        else $error("hue beyond 360 degrees");

    // Saturation within scale, pad bits clear
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sat <= SAT_MAX) && (pad == '0))
        else $error("saturation out of range or pad set");

    // Zero saturation means a grey pixel, whose hue is zero
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (sat == '0)) |-> (hue == '0))
        else $error("grey pixel with non-zero hue");

    // An empty output register never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/hsv_result_checker.sv
// Scoreboard for the RGB to HSV converter: watches both stream channels,
// works out the hue, saturation and value of every accepted pixel and compares.
// Depends on rhc_pkg for field widths, scale factors and channel codes.
module hsv_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rhc_pkg::S_TDATA_W-1:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rhc_pkg::M_TDATA_W-1:0] m_tdata,   // hue[14:0], sat[30:15], value[38:31]
    output int                            n_errors,
    output int                            n_pending
);
    import rhc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] value;
    } hsv_t;

    hsv_t hsv_expected_q[$];
    int   mismatch_count = 0;

    assign n_errors  = mismatch_count;
    assign n_pending = hsv_expected_q.size();

    function automatic hsv_t predict_hsv(input logic [IN_CHAN_W-1:0] red,
                                         input logic [IN_CHAN_W-1:0] green,
                                         input logic [IN_CHAN_W-1:0] blue);
        logic [IN_CHAN_W-1:0] chan [3];
        logic [IN_CHAN_W-1:0] top;
        logic [IN_CHAN_W-1:0] bottom;
        chan_sel_t            top_sel;
        int                   span;
        int                   diff;
        int                   num;
        int                   hue_val;
        int                   sat_val;
        hsv_t                 res;
        chan[0] = red;
        chan[1] = green;
        chan[2] = blue;
        top     = chan[0];
        bottom  = chan[0];
        top_sel = CH_RED;
        // strict compare keeps a tie for the largest on the earlier channel
        for (int k = 1; k < 3; k++) begin
            if (chan[k] > top) begin
                top     = chan[k];
                top_sel = chan_sel_t'(k);
            end else if (chan[k] < bottom) begin
                bottom = chan[k];
            end
        end
        span    = int'(top) - int'(bottom);
        hue_val = 0;
        sat_val = 0;
        if (span != 0) begin
            case (top_sel)
                CH_RED:   diff = int'(chan[1]) - int'(chan[2]);
                CH_GREEN: diff = int'(chan[2]) - int'(chan[0]);
                default:  diff = int'(chan[0]) - int'(chan[1]);
            endcase
            num = HUE_SCALE * diff + SECTOR_STEP * int'(top_sel) * span;
            if (num < 0)
                num += HUE_WRAP * span;
            hue_val = num / span;
        end
        if (top != 0)
            sat_val = (SAT_SCALE * span) / int'(top);
        res.hue   = hue_val[HUE_W-1:0];
        res.sat   = sat_val[SAT_W-1:0];
        res.value = top;
        return res;
    endfunction

    always @(posedge aclk) begin
        hsv_t exp_px;
        hsv_t got_px;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                hsv_expected_q.push_back(predict_hsv(s_tdata[7:0], s_tdata[15:8],
                                                     s_tdata[23:16]));
            if (m_tvalid && m_tready) begin
                got_px.hue   = m_tdata[HUE_LSB +: HUE_W];
                got_px.sat   = m_tdata[SAT_LSB +: SAT_W];
                got_px.value = m_tdata[VAL_LSB +: VAL_W];
                if (hsv_expected_q.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected beat: hue %0d sat %0d value %0d",
                                 got_px.hue, got_px.sat, got_px.value);
                    mismatch_count++;
                end else begin
                    exp_px = hsv_expected_q.pop_front();
                    if (got_px !== exp_px) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("mismatch: hue %0d/%0d sat %0d/%0d value %0d/%0d (exp/got)",
                                     exp_px.hue, got_px.hue, exp_px.sat, got_px.sat,
                                     exp_px.value, got_px.value);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_rgb_to_hsv_converter.sv
// Top of the RGB to HSV converter testbench: clock, reset, pixel source, result
// sink with random back-pressure, watchdog and verdict.
// Depends on rhc_pkg, rgb_to_hsv_converter and hsv_result_checker.
module tb_rgb_to_hsv_converter;
    import rhc_pkg::*;

    localparam int RANDOM_PIXELS = 450;
    localparam int FLOOD_START   = 150;  // random pixel index where the flood begins
    localparam int FLOOD_LEN     = 80;   // back-to-back beats while the sink holds off
    localparam int HOLD_CYCLES   = 150;  // long sink hold-off
    localparam int DRAIN_CYCLES  = 3 + QUO_W + 1 + 10;
    localparam int IDLE_LIMIT    = 5000;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;      // red[7:0], green[15:8], blue[23:16]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // hue[14:0], sat[30:15], value[38:31], pad[39]

    int n_errors;
    int n_pending;
    bit src_calm    = 1'b0;  // sender gives no gaps while set
    bit snk_calm    = 1'b0;  // sink stalls only for the long hold-off while set
    bit squeeze_req = 1'b0;  // ask the sink for its long hold-off

    always #5 aclk = ~aclk;

    rgb_to_hsv_converter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsv_result_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    // Mostly short gaps, now and then a long one; none at all in a calm stretch.
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one pixel and hold it until the beat is taken. Drop valid only for a
    // real gap, so valid is never lowered and raised in the same step.
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);   // idle noise on the data lines
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {blue, green, red};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random pixel, weighted towards grey, ties and values at the rails.
    task automatic send_random_pixel(input bit no_gap);
        logic [7:0] chan [3];
        logic [7:0] rail [4];
        int         kind;
        rail = '{8'd0, 8'd1, 8'd254, 8'd255};
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
            chan[k] = 8'($urandom);
        case (kind)
            0: begin
                chan[1] = chan[0];
                chan[2] = chan[0];
            end
            1: chan[$urandom_range(0, 2)] = chan[$urandom_range(0, 2)];
            2: begin
                for (int k = 0; k < 3; k++)
                    chan[k] = rail[$urandom_range(0, 3)];
            end
            default: ;
        endcase
        send_pixel(chan[0], chan[1], chan[2], no_gap);
    endtask

    // Stimulus and verdict
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rails, grey, black, every max channel, ties and the hue wrap.
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);   // black
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);   // white
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);   // grey
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);   // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);   // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);   // red and blue tie
        send_pixel(8'd255, 8'd0,   8'd1,   1'b0);   // negative hue wraps
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);   // span of one
        send_pixel(8'd255, 8'd254, 8'd254, 1'b0);
        send_pixel(8'd0,   8'd1,   8'd1,   1'b0);
        send_pixel(8'd1,   8'd0,   8'd1,   1'b0);
        send_pixel(8'd254, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd255, 8'd1,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b0);
        send_pixel(8'd1,   8'd1,   8'd0,   1'b0);
        send_pixel(8'd10,  8'd20,  8'd30,  1'b0);
        send_pixel(8'd200, 8'd100, 8'd50,  1'b0);
        send_pixel(8'd50,  8'd200, 8'd100, 1'b0);
        send_pixel(8'd100, 8'd50,  8'd200, 1'b0);
        send_pixel(8'd170, 8'd85,  8'd255, 1'b0);

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % 40 == 0)
                src_calm = ($urandom_range(0, 3) == 0);
            if (n == FLOOD_START)
                squeeze_req = 1'b1;
            send_random_pixel(n >= FLOOD_START && n < FLOOD_START + FLOOD_LEN);
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (n_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0 && n_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result sink: random stalls, calm stretches and one long hold-off while the
    // source floods, so the pipeline fills and s_tready drops.
    initial begin
        int hold;
        int run;
        int iter;
        iter = 0;
        wait (aresetn);
        forever begin
            if (iter % 16 == 0)
                snk_calm = ($urandom_range(0, 3) == 0);
            iter++;
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold        = HOLD_CYCLES;
            end else begin
                hold = pick_gap(snk_calm);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge aclk);
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule
